// ----- design/sphlc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sphlc_pkg: shared types and constants of the switch press / hold LED control
// phase and mode codes, register map, reset values and the structs that
// travel between the top level and the switch state machine
// ----------------------------------------------------------------------------
package sphlc_pkg;

	// width of the tick threshold registers and of the write data
	localparam int REG_W = 16;
	localparam int IDX_W = 2;

	// default width of the tick counters
	localparam int COUNT_WIDTH_DEF = 16;

	// register indexes
	localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [IDX_W-1:0] REG_HOLD       = 2'd1;
	localparam logic [IDX_W-1:0] REG_FLASH_HALF = 2'd2;
	localparam logic [IDX_W-1:0] REG_ACTIVE_LOW = 2'd3;

	// reset values of the registers
	localparam logic [REG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [REG_W-1:0] HOLD_RST       = 16'd1000;
	localparam logic [REG_W-1:0] FLASH_HALF_RST = 16'd100;
	localparam logic             ACTIVE_LOW_RST = 1'b1;

	// switch phase
	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_DEB_P     = 3'd1,
		PH_PRESSED   = 3'd2,
		PH_ACTION    = 3'd3,
		PH_HELD      = 3'd4,
		PH_HOLD_WAIT = 3'd5,
		PH_DEB_R     = 3'd6
	} phase_t;

	// LED mode
	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_ON    = 2'd1,
		MODE_FLASH = 2'd2
	} mode_t;

	// configuration as seen by the state machine
	typedef struct packed {
		logic [REG_W-1:0] debounce_ticks;
		logic [REG_W-1:0] hold_ticks;
		logic [REG_W-1:0] flash_half_ticks;
		logic             led_active_low;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic       led_drive;
		logic [1:0] led_mode;
		logic       short_press;
		logic       long_press;
	} res_t;

endpackage
`default_nettype wire

// ----- design/sphlc_fsm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sphlc_fsm: switch debounce / hold state machine and LED mode logic
// holds the phase, tick counters, mode and flash phase; steps once per item
// ----------------------------------------------------------------------------
module sphlc_fsm #(
	parameter int COUNT_WIDTH = sphlc_pkg::COUNT_WIDTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 adv,
	input  wire                 sw,
	input  sphlc_pkg::cfg_t     cfg,
	output sphlc_pkg::res_t     res
);

	localparam int CMP_W = (COUNT_WIDTH > sphlc_pkg::REG_W) ? COUNT_WIDTH : sphlc_pkg::REG_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	sphlc_pkg::phase_t        phase_q, phase_d;
	logic [COUNT_WIDTH-1:0]   ticks_q, ticks_d, ticks_inc;
	sphlc_pkg::mode_t         mode_q, mode_d;
	logic [COUNT_WIDTH-1:0]   fticks_q, fticks_d, fticks_inc;
	logic                     lit_q, lit_d;
	logic                     level;

	// saturating increment
	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

	// count reached threshold, threshold clipped to counter range
	function automatic logic reached(input logic [COUNT_WIDTH-1:0] c,
			input logic [sphlc_pkg::REG_W-1:0] lim);
		logic [CMP_W-1:0] c_ext;
		logic [CMP_W-1:0] l_ext;
		logic [CMP_W-1:0] m_ext;
		logic [CMP_W-1:0] t_ext;
		c_ext = CMP_W'(c);
		l_ext = CMP_W'(lim);
		m_ext = CMP_W'(CNT_MAX);
		t_ext = (l_ext > m_ext) ? m_ext : l_ext;
		return c_ext >= t_ext;
	endfunction

	assign ticks_inc  = sat_inc(ticks_q);
	assign fticks_inc = sat_inc(fticks_q);

	// next phase and phase counter
	always_comb begin
		phase_d = phase_q;
		ticks_d = ticks_q;
		unique case (phase_q)
			sphlc_pkg::PH_DEB_P: begin
				if (!sw) begin
					phase_d = sphlc_pkg::PH_IDLE;
					ticks_d = '0;
				end else if (reached(ticks_inc, cfg.debounce_ticks)) begin
					phase_d = sphlc_pkg::PH_PRESSED;
					ticks_d = '0;
				end else begin
					ticks_d = ticks_inc;
				end
			end
			sphlc_pkg::PH_PRESSED: begin
				if (!sw) begin
					phase_d = sphlc_pkg::PH_ACTION;
					ticks_d = '0;
				end else if (reached(ticks_inc, cfg.hold_ticks)) begin
					phase_d = sphlc_pkg::PH_HELD;
					ticks_d = '0;
				end else begin
					ticks_d = ticks_inc;
				end
			end
			sphlc_pkg::PH_ACTION: begin
				phase_d = sphlc_pkg::PH_DEB_R;
				ticks_d = '0;
			end
			sphlc_pkg::PH_HELD: begin
				phase_d = sphlc_pkg::PH_HOLD_WAIT;
				ticks_d = '0;
			end
			sphlc_pkg::PH_HOLD_WAIT: begin
				if (!sw) begin
					phase_d = sphlc_pkg::PH_DEB_R;
					ticks_d = '0;
				end
			end
			sphlc_pkg::PH_DEB_R: begin
				if (sw) begin
					phase_d = sphlc_pkg::PH_PRESSED;
					ticks_d = '0;
				end else if (reached(ticks_inc, cfg.debounce_ticks)) begin
					phase_d = sphlc_pkg::PH_IDLE;
					ticks_d = '0;
				end else begin
					ticks_d = ticks_inc;
				end
			end
			default: begin
				// idle, and the unused code
				phase_d = sw ? sphlc_pkg::PH_DEB_P : sphlc_pkg::PH_IDLE;
				ticks_d = '0;
			end
		endcase
	end

	// mode, flash phase and result of this item
	always_comb begin
		mode_d          = mode_q;
		fticks_d        = fticks_q;
		lit_d           = lit_q;
		res.short_press = 1'b0;
		res.long_press  = 1'b0;
		if (phase_q == sphlc_pkg::PH_ACTION) begin
			mode_d = (mode_q == sphlc_pkg::MODE_OFF) ? sphlc_pkg::MODE_ON : sphlc_pkg::MODE_OFF;
			res.short_press = 1'b1;
		end
		if (phase_q == sphlc_pkg::PH_HELD) begin
			mode_d = sphlc_pkg::MODE_FLASH;
			res.long_press = 1'b1;
		end
		unique case (mode_d)
			sphlc_pkg::MODE_FLASH: begin
				if (phase_q == sphlc_pkg::PH_HELD) begin
					// flashing starts lit
					fticks_d = '0;
					lit_d    = 1'b1;
				end else if (reached(fticks_inc, cfg.flash_half_ticks)) begin
					fticks_d = '0;
					lit_d    = ~lit_q;
				end else begin
					fticks_d = fticks_inc;
				end
				level = lit_d;
			end
			sphlc_pkg::MODE_ON: begin
				fticks_d = '0;
				lit_d    = 1'b0;
				level    = 1'b1;
			end
			default: begin
				mode_d   = sphlc_pkg::MODE_OFF;
				fticks_d = '0;
				lit_d    = 1'b0;
				level    = 1'b0;
			end
		endcase
		res.led_drive = level ^ cfg.led_active_low;
		res.led_mode  = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= sphlc_pkg::PH_IDLE;
			ticks_q  <= '0;
			mode_q   <= sphlc_pkg::MODE_OFF;
			fticks_q <= '0;
			lit_q    <= 1'b0;
		end else if (adv) begin
			phase_q  <= phase_d;
			ticks_q  <= ticks_d;
			mode_q   <= mode_d;
			fticks_q <= fticks_d;
			lit_q    <= lit_d;
		end
	end

endmodule
`default_nettype wire

// ----- design/switch_press_hold_led_control.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// switch_press_hold_led_control: debounced switch with short / long press
// and LED on, off and flashing control
// ----------------------------------------------------------------------------
// Each input item is one tick carrying the raw switch sample; each item gives
// exactly one result item with the LED pin level (after polarity), the LED
// mode and one-tick short and long press pulses. The block takes one item per
// clock cycle while the receiver does not stall: a sample is captured in an
// input register, the switch state machine and mode logic run in one short
// combinational step, and the result lands in an output register. in_stall
// only rises when a result is held in the output register by out_stall and
// another item already waits in the input register. Registers (write with
// cfg_we, cfg_index, cfg_data) are 0 debounce_ticks, 1 hold_ticks,
// 2 flash_half_ticks, 3 led_active_low; write them only while no item is in
// flight. A threshold of zero acts as one, and thresholds above the counter
// range are clipped to it.
// ----------------------------------------------------------------------------
module switch_press_hold_led_control #(
	parameter int COUNT_WIDTH = sphlc_pkg::COUNT_WIDTH_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// configuration write port
	input  wire                            cfg_we,
	input  wire [sphlc_pkg::IDX_W-1:0]     cfg_index,
	input  wire [sphlc_pkg::REG_W-1:0]     cfg_data,
	// input channel
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire                            switch_pressed,
	// output channel
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic                           led_drive,
	output logic [1:0]                     led_mode,
	output logic                           short_press,
	output logic                           long_press
);

	sphlc_pkg::cfg_t cfg_q;

	// input stage
	logic valid_s1;
	logic sw_s1;

	// output stage
	logic            out_valid_q;
	sphlc_pkg::res_t res_q;
	sphlc_pkg::res_t res;

	logic out_free;
	logic adv;

	// output register can take a result when empty or being drained
	assign out_free = !out_valid_q || !out_stall;
	// item in the input register moves on into the output register
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= sphlc_pkg::DEBOUNCE_RST;
			cfg_q.hold_ticks       <= sphlc_pkg::HOLD_RST;
			cfg_q.flash_half_ticks <= sphlc_pkg::FLASH_HALF_RST;
			cfg_q.led_active_low   <= sphlc_pkg::ACTIVE_LOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sphlc_pkg::REG_DEBOUNCE:   cfg_q.debounce_ticks   <= cfg_data;
				sphlc_pkg::REG_HOLD:       cfg_q.hold_ticks       <= cfg_data;
				sphlc_pkg::REG_FLASH_HALF: cfg_q.flash_half_ticks <= cfg_data;
				sphlc_pkg::REG_ACTIVE_LOW: cfg_q.led_active_low   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// input register: sample
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sw_s1 <= switch_pressed;
		end
	end

	// switch state machine, steps once per item leaving the input register
	sphlc_fsm #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.sw     (sw_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// output register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// output register: result item
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign led_drive   = res_q.led_drive;
	assign led_mode    = res_q.led_mode;
	assign short_press = res_q.short_press;
	assign long_press  = res_q.long_press;

endmodule
`default_nettype wire

// ----- verif/switch_press_hold_led_control_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// switch_press_hold_led_control_tb: self-checking bench for the press / hold
// LED controller
// ----------------------------------------------------------------------------
// Feeds raw switch ticks through the valid / stall input channel and checks
// every result item against a tick-accurate predictor kept in the bench.
// Directed presses, bounces, zero and full-scale thresholds come first, then
// random press sequences over several register settings and handshake duty
// cycles, and last one long hold that flashes through several half periods.
// ----------------------------------------------------------------------------
module switch_press_hold_led_control_tb;

	localparam int  CYCLE_LIMIT  = 2_000_000;
	localparam int  SETTLE_TICKS = 4;
	localparam logic [sphlc_pkg::REG_W-1:0] CNT_FULL = '1;

	// clock, reset and block ports
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                            cfg_we    = 1'b0;
	logic [sphlc_pkg::IDX_W-1:0]     cfg_index = sphlc_pkg::REG_DEBOUNCE;
	logic [sphlc_pkg::REG_W-1:0]     cfg_data  = '0;

	logic in_valid       = 1'b0;
	logic in_stall;
	logic switch_pressed = 1'b0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic led_drive;
	logic [1:0] led_mode;
	logic short_press;
	logic long_press;

	// handshake duty cycles, in percent
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;

	// bookkeeping
	int errors       = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int reg_writes   = 0;
	int shorts_seen  = 0;
	int holds_seen   = 0;
	int cycles       = 0;

	// led results still owed by the block, oldest first
	sphlc_pkg::res_t led_results_due[$];

	// predictor copy of the registers
	logic [sphlc_pkg::REG_W-1:0] db_lim;
	logic [sphlc_pkg::REG_W-1:0] hold_lim;
	logic [sphlc_pkg::REG_W-1:0] flash_lim;
	logic                        act_low;

	// predictor copy of the block state
	sphlc_pkg::phase_t           sw_phase;
	logic [sphlc_pkg::REG_W-1:0] ph_cnt;
	sphlc_pkg::mode_t            mode_q;
	logic [sphlc_pkg::REG_W-1:0] fl_cnt;
	logic                        fl_lit;

	switch_press_hold_led_control dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.switch_pressed (switch_pressed),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.led_drive      (led_drive),
		.led_mode       (led_mode),
		.short_press    (short_press),
		.long_press     (long_press)
	);

	always #5 clk = ~clk;

	// run-away guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				led_results_due.size());
			$display("FAIL switch_press_hold_led_control");
			$finish;
		end
	end

	// receiver back-pressure, changes only on the falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// saturating tick counter
	function automatic logic [sphlc_pkg::REG_W-1:0] sat_inc(
			input logic [sphlc_pkg::REG_W-1:0] c);
		return (c == CNT_FULL) ? c : c + 1'b1;
	endfunction

	// one tick of the controller: advance the predictor state, give the result
	function automatic sphlc_pkg::res_t led_tick_predict(input logic sw);
		sphlc_pkg::res_t r;
		logic flash_start;
		logic lvl;
		r = '0;
		flash_start = 1'b0;
		case (sw_phase)
			sphlc_pkg::PH_DEB_P: begin
				if (!sw) begin
					sw_phase = sphlc_pkg::PH_IDLE;
					ph_cnt = '0;
				end else begin
					ph_cnt = sat_inc(ph_cnt);
					// a zero threshold is met on the first count, like one
					if (ph_cnt >= db_lim) begin
						sw_phase = sphlc_pkg::PH_PRESSED;
						ph_cnt = '0;
					end
				end
			end
			sphlc_pkg::PH_PRESSED: begin
				if (!sw) begin
					sw_phase = sphlc_pkg::PH_ACTION;
					ph_cnt = '0;
				end else begin
					ph_cnt = sat_inc(ph_cnt);
					if (ph_cnt >= hold_lim) begin
						sw_phase = sphlc_pkg::PH_HELD;
						ph_cnt = '0;
					end
				end
			end
			sphlc_pkg::PH_ACTION: begin
				// short press: off goes on, on and flashing both go off
				if (mode_q == sphlc_pkg::MODE_OFF)
					mode_q = sphlc_pkg::MODE_ON;
				else
					mode_q = sphlc_pkg::MODE_OFF;
				r.short_press = 1'b1;
				sw_phase = sphlc_pkg::PH_DEB_R;
				ph_cnt = '0;
			end
			sphlc_pkg::PH_HELD: begin
				mode_q = sphlc_pkg::MODE_FLASH;
				fl_cnt = '0;
				fl_lit = 1'b1;
				flash_start = 1'b1;
				r.long_press = 1'b1;
				sw_phase = sphlc_pkg::PH_HOLD_WAIT;
				ph_cnt = '0;
			end
			sphlc_pkg::PH_HOLD_WAIT: begin
				if (!sw) begin
					sw_phase = sphlc_pkg::PH_DEB_R;
					ph_cnt = '0;
				end
			end
			sphlc_pkg::PH_DEB_R: begin
				// a bounce back to pressed restarts the press timing
				if (sw) begin
					sw_phase = sphlc_pkg::PH_PRESSED;
					ph_cnt = '0;
				end else begin
					ph_cnt = sat_inc(ph_cnt);
					if (ph_cnt >= db_lim) begin
						sw_phase = sphlc_pkg::PH_IDLE;
						ph_cnt = '0;
					end
				end
			end
			default: begin
				sw_phase = sw ? sphlc_pkg::PH_DEB_P : sphlc_pkg::PH_IDLE;
				ph_cnt = '0;
			end
		endcase

		if (mode_q == sphlc_pkg::MODE_FLASH) begin
			// the tick that starts flashing does not count toward the half period
			if (!flash_start) begin
				fl_cnt = sat_inc(fl_cnt);
				if (fl_cnt >= flash_lim) begin
					fl_lit = ~fl_lit;
					fl_cnt = '0;
				end
			end
			lvl = fl_lit;
		end else begin
			// leaving flashing clears the flash timing
			fl_cnt = '0;
			fl_lit = 1'b0;
			lvl = (mode_q == sphlc_pkg::MODE_ON);
		end

		r.led_drive = lvl ^ act_low;
		r.led_mode = mode_q;
		return r;
	endfunction

	// send one tick and book its expected result once it is taken
	task automatic send_tick(input logic sw);
		logic [31:0] junk;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			junk = $urandom_range(1);
			in_valid <= 1'b0;
			switch_pressed <= junk[0];
			@(negedge clk);
		end
		in_valid <= 1'b1;
		switch_pressed <= sw;
		do @(posedge clk); while (in_stall);
		led_results_due.push_back(led_tick_predict(sw));
		items_sent++;
	endtask

	// hold the switch at one level for a number of ticks
	task automatic send_level(input logic sw, input int n);
		repeat (n) send_tick(sw);
	endtask

	// stop sending and wait until the block has nothing in flight
	task automatic drain_block;
		@(negedge clk);
		in_valid <= 1'b0;
		while (led_results_due.size() != 0) @(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	task automatic write_reg(input logic [sphlc_pkg::IDX_W-1:0] idx,
			input logic [sphlc_pkg::REG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sphlc_pkg::REG_DEBOUNCE:   db_lim = data;
			sphlc_pkg::REG_HOLD:       hold_lim = data;
			sphlc_pkg::REG_FLASH_HALF: flash_lim = data;
			sphlc_pkg::REG_ACTIVE_LOW: act_low = data[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_timing(input logic [sphlc_pkg::REG_W-1:0] db,
			input logic [sphlc_pkg::REG_W-1:0] hold,
			input logic [sphlc_pkg::REG_W-1:0] flash, input logic low);
		drain_block();
		write_reg(sphlc_pkg::REG_DEBOUNCE, db);
		write_reg(sphlc_pkg::REG_HOLD, hold);
		write_reg(sphlc_pkg::REG_FLASH_HALF, flash);
		write_reg(sphlc_pkg::REG_ACTIVE_LOW, {{(sphlc_pkg::REG_W-1){1'b0}}, low});
	endtask

	task automatic report_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// result checker: every accepted result item against the oldest expectation
	always @(posedge clk) begin
		sphlc_pkg::res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (led_results_due.size() == 0) begin
				$display("%0t ns: unexpected result item, expected none, got drive %0b mode %0d",
					$time, led_drive, led_mode);
				errors++;
			end else begin
				want = led_results_due.pop_front();
				report_field("led_drive", want.led_drive, led_drive);
				report_field("led_mode", want.led_mode, led_mode);
				report_field("short_press", want.short_press, short_press);
				report_field("long_press", want.long_press, long_press);
				results_seen++;
				if (short_press) shorts_seen++;
				if (long_press) holds_seen++;
			end
		end
	end

	// a few ticks on the reset values: LED off, active low, long debounce
	task automatic test_reset_values;
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
	endtask

	// short press from off, hold into flashing, short press out of flashing
	task automatic test_press_kinds;
		set_timing(16'd1, 16'd3, 16'd1, 1'b0);
		send_level(1'b1, 3);
		send_level(1'b0, 3);
		send_level(1'b1, 8);
		send_level(1'b0, 3);
		send_level(1'b1, 3);
		send_level(1'b0, 3);
	endtask

	// zero thresholds act as one; bounces during both debounce phases
	task automatic test_bounce_zero_threshold;
		set_timing(16'd0, 16'd0, 16'd0, 1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_level(1'b1, 4);
		send_tick(1'b0);
		send_tick(1'b1);
		send_level(1'b0, 3);
	endtask

	// full-scale thresholds: nothing completes, every register bit set
	task automatic test_register_extremes;
		set_timing(CNT_FULL, CNT_FULL, CNT_FULL, 1'b1);
		send_level(1'b1, 5);
		send_level(1'b0, 5);
	endtask

	// random register setting with short timings so sequences reach deep
	task automatic pick_random_timing;
		logic [31:0] r_db;
		logic [31:0] r_hold;
		logic [31:0] r_flash;
		logic [31:0] r_low;
		r_db = $urandom_range(4);
		r_hold = $urandom_range(10);
		r_flash = $urandom_range(5);
		r_low = $urandom_range(1);
		set_timing(r_db[sphlc_pkg::REG_W-1:0], r_hold[sphlc_pkg::REG_W-1:0],
			r_flash[sphlc_pkg::REG_W-1:0], r_low[0]);
	endtask

	// mostly well-formed presses of random length, some bounces and noise
	task automatic test_random_presses(input int n_items);
		int start_cnt;
		int unsigned kind;
		int on_len;
		int off_len;
		logic [31:0] noise;
		start_cnt = items_sent;
		pick_random_timing();
		while (items_sent - start_cnt < n_items) begin
			kind = $urandom_range(15);
			if (kind == 0) begin
				pick_random_timing();
			end else if (kind < 11) begin
				// clean press, length around the short / hold boundary
				on_len = $urandom_range(1, db_lim + hold_lim + 3 * flash_lim + 4);
				off_len = $urandom_range(1, db_lim + 3);
				send_level(1'b1, on_len);
				send_level(1'b0, off_len);
			end else if (kind < 14) begin
				// press with a bounce somewhere in it
				send_level(1'b1, $urandom_range(1, db_lim + 2));
				send_level(1'b0, $urandom_range(1, 2));
				send_level(1'b1, $urandom_range(1, hold_lim + 3));
				send_level(1'b0, $urandom_range(1, db_lim + 3));
			end else begin
				repeat ($urandom_range(1, 6)) begin
					noise = $urandom_range(1);
					send_tick(noise[0]);
				end
			end
		end
	endtask

	// one long hold that flashes through several half periods
	task automatic test_long_hold_limit;
		set_timing(16'd3, 16'd40, 16'd9, 1'b0);
		send_level(1'b1, 3 + 40 + 4 * 9 + 6);
		send_level(1'b0, 6);
	endtask

	initial begin
		db_lim = sphlc_pkg::DEBOUNCE_RST;
		hold_lim = sphlc_pkg::HOLD_RST;
		flash_lim = sphlc_pkg::FLASH_HALF_RST;
		act_low = sphlc_pkg::ACTIVE_LOW_RST;
		sw_phase = sphlc_pkg::PH_IDLE;
		ph_cnt = '0;
		mode_q = sphlc_pkg::MODE_OFF;
		fl_cnt = '0;
		fl_lit = 1'b0;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// sender idles a fifth of the time, receiver stalls half
		send_idle_pct = 20;
		recv_stall_pct = 50;
		test_reset_values();
		test_press_kinds();
		test_bounce_zero_threshold();
		test_register_extremes();
		test_random_presses(330);

		// hold the sender back until every owed result has come out
		drain_block();

		// roles swapped
		send_idle_pct = 50;
		recv_stall_pct = 20;
		test_random_presses(330);

		// full rate both ways
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_presses(330);
		test_long_hold_limit();

		drain_block();
		if (led_results_due.size() != 0) begin
			$display("%0t ns: %0d expected results never came", $time, led_results_due.size());
			errors++;
		end

		$display("run: %0d ticks sent, %0d results checked, %0d register writes",
			items_sent, results_seen, reg_writes);
		$display("seen %0d short presses and %0d holds, %0d mismatches",
			shorts_seen, holds_seen, errors);
		if (errors == 0)
			$display("PASS switch_press_hold_led_control");
		else
			$display("FAIL switch_press_hold_led_control");
		$finish;
	end

endmodule

// ----- files.f -----
design/sphlc_pkg.sv
design/sphlc_fsm.sv
design/switch_press_hold_led_control.sv
verif/switch_press_hold_led_control_tb.sv
